// ===== hdl/pcfg_pkg.sv =====
// Shared types, codes and helpers of the PCI configuration access sequencer.
`timescale 1ns / 1ps
package pcfg_pkg;

  // Command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_RESP  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // Access sizes
  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_DWORD = 2'd2;
  localparam logic [1:0] SIZE_BAD   = 2'd3;

  // Access methods
  localparam logic [1:0] METHOD_NONE  = 2'd0;
  localparam logic [1:0] METHOD_TYPE1 = 2'd1;
  localparam logic [1:0] METHOD_TYPE2 = 2'd2;

  // Completion status
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOSUP    = 2'd1;
  localparam logic [1:0] STATUS_BADREG   = 2'd2;
  localparam logic [1:0] STATUS_NODEVICE = 2'd3;

  // Result kinds
  localparam logic KIND_IO   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Legacy I/O ports
  localparam logic [15:0] PORT_ADDR  = 16'hCF8;
  localparam logic [15:0] PORT_DATA  = 16'hCFC;
  localparam logic [15:0] PORT_FWD   = 16'hCFA;
  localparam logic [3:0]  WIN2_BASE  = 4'hC;
  localparam logic [3:0]  FUNC_EN_HI = 4'hF;

  localparam int STEP_W = 3;

  typedef enum logic [2:0] {
    JOB_DONE,     // single completion
    JOB_T1_RD,    // address write, data read
    JOB_T1_WR,    // address write, data write, completion
    JOB_T2_RD,    // enable write, bus write, window read
    JOB_T2_WR,    // enable, bus, window write, disable, completion
    JOB_RESP2     // disable, completion
  } job_op_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  access_size;
    logic [7:0]  bus_number;
    logic [7:0]  device_function;
    logic [7:0]  register_offset;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        io_write;
    logic [1:0]  io_size;
    logic [15:0] io_port;
    logic [31:0] io_data;
    logic [1:0]  status;
    logic [31:0] read_data;
    logic        last;
  } out_item_t;

  typedef struct packed {
    job_op_t     op;
    logic [1:0]  size;
    logic [15:0] port;
    logic [31:0] addr;
    logic [7:0]  bus;
    logic [31:0] data;
    logic [1:0]  status;
  } job_t;

  function automatic logic [31:0] size_mask(input logic [1:0] size);
    logic [31:0] m;
    case (size)
      SIZE_BYTE: m = 32'h0000_00FF;
      SIZE_WORD: m = 32'h0000_FFFF;
      default:   m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [STEP_W-1:0] job_steps(input job_op_t op);
    logic [STEP_W-1:0] n;
    case (op)
      JOB_DONE:  n = 3'd1;
      JOB_T1_RD: n = 3'd2;
      JOB_T1_WR: n = 3'd3;
      JOB_T2_RD: n = 3'd3;
      JOB_T2_WR: n = 3'd5;
      JOB_RESP2: n = 3'd2;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/pci_config_access_sequencer_unit.sv =====
// Top level of the PCI configuration access sequencer.
`timescale 1ns / 1ps
// Usage:
//   cfg_we/cfg_wdata write the access method (none, type 1, type 2); write it
//   only while no transaction is in flight.
//   Input channel (in_valid, in_stall, in): config read, config write or I/O
//   read response. Output channel (out_valid, out_stall, out): I/O bus cycles
//   and request completions, with last set on the final result of an input.
// Path: an accepted transaction is written into the job queue, and its
//   results are registered in the output register.
// Throughput: one result per cycle out of the cycle sequencer while out_stall
//   does not hold it; a request yields 1 to 5 results, and type 2 writes yield 5.
//   The front end accepts one transaction per cycle until the job queue of
//   QUEUE_DEPTH entries fills; responses with nothing pending and unused
//   command codes are absorbed without a result.
// Reset: rst clears the access method to none, drops any pending read and
//   empties the queue and output register.
// Stall: when out_stall is high the current result holds; the sequencer
//   freezes, the queue fills, and then in_stall rises.
module pci_config_access_sequencer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcfg_pkg::in_item_t  in,
  output logic                out_valid,
  input  logic                out_stall,
  output pcfg_pkg::out_item_t out
);
  import pcfg_pkg::*;

  // Front end to queue
  logic q_full;
  logic push;
  job_t push_job;

  // Queue to back end
  logic head_valid;
  job_t head_job;
  logic pop;

  // Classify the transaction and track the outstanding read.
  pcfg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Hold classified jobs so the two sides stall independently.
  pcfg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  // Expand each job into its I/O bus accesses and completion.
  pcfg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out)
  );

endmodule

// ===== hdl/pcfg_front.sv =====
// Front end: accepts transactions, tracks the pending read and classifies jobs.
`timescale 1ns / 1ps
module pcfg_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  pcfg_pkg::in_item_t in_item,
  input  logic             q_full,
  output logic             push,
  output pcfg_pkg::job_t   push_job
);
  import pcfg_pkg::*;

  logic       accept;
  logic [1:0] access_method;
  logic       read_pending, read_pending_next;
  logic [1:0] pending_size, pending_size_next;
  logic       pending_conf2, pending_conf2_next;
  logic       has_job;
  logic       is_read;
  logic       misaligned;
  logic [1:0] lane;
  logic [31:0] wmask;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && has_job;

  assign is_read = (in_item.cmd == CMD_READ);
  assign wmask   = in_item.write_data & size_mask(in_item.access_size);
  assign misaligned = ((in_item.access_size == SIZE_WORD) && in_item.register_offset[0]) ||
                      ((in_item.access_size == SIZE_DWORD) &&
                       (in_item.register_offset[1:0] != 2'b00));

  always_comb begin
    case (in_item.access_size)
      SIZE_BYTE: lane = in_item.register_offset[1:0];
      SIZE_WORD: lane = {in_item.register_offset[1], 1'b0};
      default:   lane = 2'b00;
    endcase
  end

  always_comb begin
    has_job            = 1'b0;
    read_pending_next  = read_pending;
    pending_size_next  = pending_size;
    pending_conf2_next = pending_conf2;
    push_job           = '0;
    push_job.op        = JOB_DONE;
    push_job.size      = in_item.access_size;
    push_job.bus       = in_item.bus_number;
    case (in_item.cmd)
      CMD_RESP: begin
        if (read_pending) begin
          has_job           = 1'b1;
          read_pending_next = 1'b0;
          push_job.op       = pending_conf2 ? JOB_RESP2 : JOB_DONE;
          push_job.status   = STATUS_OK;
          push_job.data     = in_item.write_data & size_mask(pending_size);
        end
      end
      CMD_READ, CMD_WRITE: begin
        has_job           = 1'b1;
        read_pending_next = 1'b0;
        if (in_item.access_size == SIZE_BAD) begin
          push_job.status = STATUS_BADREG;
        end else if (access_method == METHOD_TYPE1) begin
          if (misaligned) begin
            push_job.status = STATUS_BADREG;
          end else begin
            push_job.op   = is_read ? JOB_T1_RD : JOB_T1_WR;
            push_job.addr = {1'b1, 7'd0, in_item.bus_number, in_item.device_function,
                             in_item.register_offset[7:2], 2'b00};
            push_job.port = PORT_DATA + {14'd0, lane};
            push_job.data = is_read ? 32'd0 : wmask;
            if (is_read) begin
              read_pending_next  = 1'b1;
              pending_size_next  = in_item.access_size;
              pending_conf2_next = 1'b0;
            end
          end
        end else if (access_method == METHOD_TYPE2) begin
          if (is_read && in_item.device_function[7]) begin
            push_job.status = STATUS_NODEVICE;
          end else begin
            push_job.op   = is_read ? JOB_T2_RD : JOB_T2_WR;
            push_job.addr = {24'd0, FUNC_EN_HI, in_item.device_function[2:0], 1'b0};
            // base has a zero low byte, so adding the offset is a concatenation
            push_job.port = {WIN2_BASE, in_item.device_function[6:3],
                             in_item.register_offset};
            push_job.data = is_read ? 32'd0 : wmask;
            if (is_read) begin
              read_pending_next  = 1'b1;
              pending_size_next  = in_item.access_size;
              pending_conf2_next = 1'b1;
            end
          end
        end else begin
          push_job.status = STATUS_NOSUP;
        end
      end
      default: begin
        has_job = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_method <= METHOD_NONE;
      read_pending  <= 1'b0;
      pending_size  <= SIZE_BYTE;
      pending_conf2 <= 1'b0;
    end else begin
      if (cfg_we) begin
        access_method <= cfg_wdata;
      end
      if (accept) begin
        read_pending  <= read_pending_next;
        pending_size  <= pending_size_next;
        pending_conf2 <= pending_conf2_next;
      end
    end
  end

endmodule

// ===== hdl/pcfg_queue.sv =====
// Job queue between the front end and the cycle sequencer.
`timescale 1ns / 1ps
module pcfg_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pcfg_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output pcfg_pkg::job_t head_job
);
  import pcfg_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== hdl/pcfg_back.sv =====
// Back end: steps through a job and emits one I/O cycle or completion per cycle unless out_stall holds it.
`timescale 1ns / 1ps
module pcfg_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  pcfg_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pcfg_pkg::out_item_t out_item
);
  import pcfg_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] n_steps;
  logic              load;
  logic              final_step;
  out_item_t         res;

  assign n_steps    = job_steps(head_job.op);
  assign final_step = (step == n_steps - 1'b1);
  assign load       = head_valid && (!out_valid || !out_stall);
  assign pop        = load && final_step;

  always_comb begin
    res      = '0;
    res.last = final_step;
    case (head_job.op)
      JOB_T1_RD, JOB_T1_WR: begin
        case (step)
          3'd0: begin
            res.io_write = 1'b1;
            res.io_size  = SIZE_DWORD;
            res.io_port  = PORT_ADDR;
            res.io_data  = head_job.addr;
          end
          3'd1: begin
            res.io_write = (head_job.op == JOB_T1_WR);
            res.io_size  = head_job.size;
            res.io_port  = head_job.port;
            res.io_data  = head_job.data;
          end
          default: begin
            res.kind   = KIND_DONE;
            res.status = STATUS_OK;
          end
        endcase
      end
      JOB_T2_RD, JOB_T2_WR: begin
        case (step)
          3'd0: begin
            res.io_write = 1'b1;
            res.io_size  = SIZE_BYTE;
            res.io_port  = PORT_ADDR;
            res.io_data  = head_job.addr;
          end
          3'd1: begin
            res.io_write = 1'b1;
            res.io_size  = SIZE_BYTE;
            res.io_port  = PORT_FWD;
            res.io_data  = {24'd0, head_job.bus};
          end
          3'd2: begin
            res.io_write = (head_job.op == JOB_T2_WR);
            res.io_size  = head_job.size;
            res.io_port  = head_job.port;
            res.io_data  = head_job.data;
          end
          3'd3: begin
            res.io_write = 1'b1;
            res.io_size  = SIZE_BYTE;
            res.io_port  = PORT_ADDR;
          end
          default: begin
            res.kind   = KIND_DONE;
            res.status = STATUS_OK;
          end
        endcase
      end
      JOB_RESP2: begin
        if (step == '0) begin
          res.io_write = 1'b1;
          res.io_size  = SIZE_BYTE;
          res.io_port  = PORT_ADDR;
        end else begin
          res.kind      = KIND_DONE;
          res.status    = STATUS_OK;
          res.read_data = head_job.data;
        end
      end
      default: begin
        res.kind      = KIND_DONE;
        res.status    = head_job.status;
        res.read_data = head_job.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= final_step ? '0 : step + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_step_in_job: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> step < n_steps)
    else $error("step beyond job length");
  a_step_needs_job: assert property (@(posedge clk) disable iff (rst)
    step != '0 |-> head_valid)
    else $error("job left the queue mid-sequence");
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.kind == KIND_DONE) |-> out_item.last)
    else $error("completion not marked last");
`endif

endmodule

// ===== dv/pcfg_cycle_checker.sv =====
// Checker for the PCI configuration sequencer: predicts I/O bus accesses and completions.
`timescale 1ns / 1ps
module pcfg_cycle_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  pcfg_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pcfg_pkg::out_item_t out_item,
  output int                  mismatches = 0,
  output int                  results_owed = 0
);
  import pcfg_pkg::*;

  logic [1:0] method;
  logic       read_open;
  logic [1:0] open_size;
  logic       open_via_type2;
  out_item_t  owed_q[$];

  function automatic logic [31:0] width_mask(input logic [1:0] size);
    case (size)
      SIZE_BYTE: return 32'h0000_00FF;
      SIZE_WORD: return 32'h0000_FFFF;
      default:   return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic out_item_t io_cycle(input logic wr, input logic [1:0] size,
                                         input logic [15:0] port, input logic [31:0] data);
    out_item_t r;
    r          = '0;
    r.kind     = KIND_IO;
    r.io_write = wr;
    r.io_size  = size;
    r.io_port  = port;
    r.io_data  = wr ? data : 32'h0;
    return r;
  endfunction

  function automatic out_item_t completion(input logic [1:0] st, input logic [31:0] rdata);
    out_item_t r;
    r           = '0;
    r.kind      = KIND_DONE;
    r.status    = st;
    r.read_data = rdata;
    return r;
  endfunction

  function automatic string describe(input out_item_t r);
    return $sformatf("kind=%0d wr=%0d size=%0d port=%h data=%h status=%0d rdata=%h last=%0d",
                     r.kind, r.io_write, r.io_size, r.io_port, r.io_data, r.status,
                     r.read_data, r.last);
  endfunction

  task automatic predict_results(input in_item_t t);
    int          first;
    logic        is_read;
    logic [31:0] wmasked;
    logic [15:0] lane;
    logic [15:0] win_port;
    out_item_t   tail;
    first   = owed_q.size();
    is_read = (t.cmd == CMD_READ);
    wmasked = t.write_data & width_mask(t.access_size);
    if (t.cmd == CMD_RESP) begin
      if (read_open) begin
        if (open_via_type2) owed_q.push_back(io_cycle(1'b1, SIZE_BYTE, PORT_ADDR, 32'h0));
        owed_q.push_back(completion(STATUS_OK, t.write_data & width_mask(open_size)));
        read_open = 1'b0;
      end
    end else if (t.cmd != CMD_NONE) begin
      // a new request drops any read still waiting for its response
      read_open = 1'b0;
      if (t.access_size == SIZE_BAD) begin
        owed_q.push_back(completion(STATUS_BADREG, 32'h0));
      end else if (method == METHOD_TYPE1) begin
        if ((t.access_size == SIZE_WORD && t.register_offset[0]) ||
            (t.access_size == SIZE_DWORD && t.register_offset[1:0] != 2'b00)) begin
          owed_q.push_back(completion(STATUS_BADREG, 32'h0));
        end else begin
          case (t.access_size)
            SIZE_BYTE: lane = {14'd0, t.register_offset[1:0]};
            SIZE_WORD: lane = {14'd0, t.register_offset[1], 1'b0};
            default:   lane = 16'd0;
          endcase
          owed_q.push_back(io_cycle(1'b1, SIZE_DWORD, PORT_ADDR,
                                    {1'b1, 7'd0, t.bus_number, t.device_function,
                                     t.register_offset[7:2], 2'b00}));
          if (is_read) begin
            owed_q.push_back(io_cycle(1'b0, t.access_size, PORT_DATA + lane, 32'h0));
            read_open      = 1'b1;
            open_size      = t.access_size;
            open_via_type2 = 1'b0;
          end else begin
            owed_q.push_back(io_cycle(1'b1, t.access_size, PORT_DATA + lane, wmasked));
            owed_q.push_back(completion(STATUS_OK, 32'h0));
          end
        end
      end else if (method == METHOD_TYPE2) begin
        if (is_read && t.device_function[7]) begin
          owed_q.push_back(completion(STATUS_NODEVICE, 32'h0));
        end else begin
          win_port = {WIN2_BASE, t.device_function[6:3], 8'h00} + {8'h00, t.register_offset};
          owed_q.push_back(io_cycle(1'b1, SIZE_BYTE, PORT_ADDR,
                                    {24'd0, FUNC_EN_HI, t.device_function[2:0], 1'b0}));
          owed_q.push_back(io_cycle(1'b1, SIZE_BYTE, PORT_FWD, {24'd0, t.bus_number}));
          if (is_read) begin
            owed_q.push_back(io_cycle(1'b0, t.access_size, win_port, 32'h0));
            read_open      = 1'b1;
            open_size      = t.access_size;
            open_via_type2 = 1'b1;
          end else begin
            owed_q.push_back(io_cycle(1'b1, t.access_size, win_port, wmasked));
            owed_q.push_back(io_cycle(1'b1, SIZE_BYTE, PORT_ADDR, 32'h0));
            owed_q.push_back(completion(STATUS_OK, 32'h0));
          end
        end
      end else begin
        owed_q.push_back(completion(STATUS_NOSUP, 32'h0));
      end
    end
    // mark the final result of this transaction
    if (owed_q.size() > first) begin
      tail      = owed_q.pop_back();
      tail.last = 1'b1;
      owed_q.push_back(tail);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (owed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: %s", describe(got));
    end else begin
      want = owed_q.pop_front();
      if (got.kind !== want.kind || got.io_write !== want.io_write ||
          got.io_size !== want.io_size || got.io_port !== want.io_port ||
          got.io_data !== want.io_data || got.status !== want.status ||
          got.read_data !== want.read_data || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected: %s", describe(want));
          $display("  actual:   %s", describe(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      method         = METHOD_NONE;
      read_open      = 1'b0;
      open_size      = SIZE_BYTE;
      open_via_type2 = 1'b0;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_item);
      if (in_valid && !in_stall) predict_results(in_item);
      if (cfg_we) method = cfg_wdata;
    end
    results_owed = owed_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the PCI configuration sequencer: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb;
  import pcfg_pkg::*;

  // Code the package leaves out: the method alias of none
  localparam logic [1:0] METHOD_ALIAS = 2'd3;

  localparam int HOLD_CYCLES      = 300;    // long receiver hold-off
  localparam int SETTLE_CYCLES    = 20;     // covers queue depth plus absorbed transactions
  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 30;
  localparam int NUM_PHASES       = 8;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cfg_we    = 1'b0;
  logic [1:0] cfg_wdata = METHOD_NONE;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  req_item  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t res_item;

  int         mismatches;
  int         results_owed;
  idle_mode_t idle_mode   = IDLE_NONE;
  logic       long_hold   = 1'b0;
  int         hold_count  = 0;
  int         cycle_count = 0;

  // Per-phase method and idling pattern; phase 3 carries the long hold-off
  logic [1:0] phase_method[NUM_PHASES] = '{METHOD_TYPE1, METHOD_TYPE2, METHOD_TYPE1,
                                           METHOD_TYPE2, METHOD_NONE, METHOD_TYPE1,
                                           METHOD_TYPE2, METHOD_ALIAS};
  idle_mode_t phase_idle[NUM_PHASES]   = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_NONE,
                                           IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

  always #4 clk = ~clk;

  pci_config_access_sequencer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in        (req_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out       (res_item)
  );

  pcfg_cycle_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (req_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (res_item),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Receiver side: honor the long hold-off first, then stall per the idling pattern.
  always @(negedge clk) begin
    if (long_hold && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_stall  <= 1'b1;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_stall <= chance(72);
        IDLE_BOTH:     out_stall <= chance(9);
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one transaction and hold it until accepted. Enter and leave at a falling
  // edge; valid stays high on exit so back-to-back transactions need no toggle.
  task automatic send(input logic [1:0] cmd, input logic [1:0] size, input logic [7:0] bus,
                      input logic [7:0] devfn, input logic [7:0] offset,
                      input logic [31:0] data);
    in_item_t t;
    t.cmd             = cmd;
    t.access_size     = size;
    t.bus_number      = bus;
    t.device_function = devfn;
    t.register_offset = offset;
    t.write_data      = data;
    while ((idle_mode == IDLE_SENDER && chance(72)) || (idle_mode == IDLE_BOTH && chance(9)))
    begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_item <= t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, wait out every owed result, then let absorbed transactions drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the access method; only called while the block is idle.
  task automatic set_method(input logic [1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [1:0]  size;
    logic [7:0]  bus;
    logic [7:0]  devfn;
    logic [7:0]  offset;
    logic [31:0] data;
    int          pick;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Type 1: lane selection, alignment checks, bad size, stray responses, dropped read
    set_method(METHOD_TYPE1);
    send(CMD_READ,  SIZE_BYTE,  8'h00, 8'h00, 8'h00, 32'h0);
    send(CMD_RESP,  SIZE_BYTE,  8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
    send(CMD_WRITE, SIZE_DWORD, 8'hFF, 8'hFF, 8'hFC, 32'hFFFF_FFFF);
    send(CMD_WRITE, SIZE_WORD,  8'h12, 8'h34, 8'h03, 32'hCAFE_F00D);
    send(CMD_READ,  SIZE_DWORD, 8'h12, 8'h34, 8'h02, 32'h0);
    send(CMD_READ,  SIZE_WORD,  8'h5A, 8'hA5, 8'h02, 32'h0);
    send(CMD_RESP,  SIZE_DWORD, 8'hFF, 8'hFF, 8'hFF, 32'hAAAA_5555);
    send(CMD_WRITE, SIZE_BAD,   8'h01, 8'h08, 8'h03, 32'h1234_5678);
    send(CMD_RESP,  SIZE_WORD,  8'h00, 8'h00, 8'h00, 32'h8765_4321);
    send(CMD_NONE,  SIZE_DWORD, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send(CMD_READ,  SIZE_DWORD, 8'h80, 8'h10, 8'hFC, 32'h0);
    send(CMD_WRITE, SIZE_BYTE,  8'h80, 8'h10, 8'hFF, 32'h0000_01C3);
    send(CMD_RESP,  SIZE_BYTE,  8'h00, 8'h00, 8'h00, 32'h0BAD_0BAD);
    settle();

    // Type 2: absent device on read, write to the top of the window, full read
    set_method(METHOD_TYPE2);
    send(CMD_READ,  SIZE_BYTE,  8'h01, 8'h80, 8'h00, 32'h0);
    send(CMD_RESP,  SIZE_BYTE,  8'h00, 8'h00, 8'h00, 32'h1111_1111);
    send(CMD_WRITE, SIZE_WORD,  8'hFF, 8'hFF, 8'hFF, 32'h1234_5678);
    send(CMD_READ,  SIZE_DWORD, 8'hA5, 8'h7F, 8'h10, 32'h0);
    send(CMD_RESP,  SIZE_BYTE,  8'h00, 8'h00, 8'h00, 32'hDEAD_BEEF);
    settle();

    // No method, through both encodings
    set_method(METHOD_NONE);
    send(CMD_READ,  SIZE_DWORD, 8'h00, 8'h00, 8'h00, 32'h0);
    send(CMD_WRITE, SIZE_BYTE,  8'h00, 8'h00, 8'h00, 32'hFF);
    settle();
    set_method(METHOD_ALIAS);
    send(CMD_WRITE, SIZE_WORD,  8'hFF, 8'hFF, 8'hFE, 32'hFFFF);
    send(CMD_READ,  SIZE_BYTE,  8'hFF, 8'hFF, 8'hFF, 32'h0);
    settle();

    // Random phases: mostly read/response pairs and writes with random content,
    // with some stray responses, unused commands and reads cut off by a new request.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_method(phase_method[ph]);
      idle_mode <= phase_idle[ph];
      if (ph == 3) long_hold <= 1'b1;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        size   = chance(6) ? SIZE_BAD : 2'($urandom_range(2));
        bus    = 8'($urandom);
        devfn  = 8'($urandom);
        offset = 8'($urandom);
        data   = $urandom;
        if (!chance(25)) begin
          if (size == SIZE_WORD) offset[0] = 1'b0;
          else if (size == SIZE_DWORD) offset[1:0] = 2'b00;
        end
        pick = $urandom_range(99);
        if (pick < 45) begin
          send(CMD_READ, size, bus, devfn, offset, data);
          if (!chance(10))
            send(CMD_RESP, 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
        end else if (pick < 80) begin
          send(CMD_WRITE, size, bus, devfn, offset, data);
        end else if (pick < 88) begin
          send(CMD_RESP, size, bus, devfn, offset, data);
        end else if (pick < 93) begin
          send(CMD_NONE, size, bus, devfn, offset, data);
        end else begin
          // read cut off by the next request, then a late response
          send(CMD_READ, size, bus, devfn, offset, data);
          send(CMD_WRITE, size, bus, devfn, offset, ~data);
          send(CMD_RESP, size, bus, devfn, offset, $urandom);
        end
      end
      settle();
    end

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
